// File: sv/rar_pkg.sv
// Package for the rational arithmetic reduce unit.
// Holds the operation codes and the field widths; it depends on nothing else.
package rar_pkg;

    localparam int NUM_W = 32;   // input numerator width
    localparam int DEN_W = 31;   // input denominator width
    localparam int RES_W = 64;   // result numerator width
    localparam int RDEN_W = 63;  // result denominator width

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

endpackage

// File: sv/rational_arith_reduce_unit.sv
// Rational arithmetic unit: forms a sum, difference, product or quotient of two
// fractions and reduces it by a binary gcd and two restoring divisions.
// Depends on rar_pkg for the operation codes and field widths.
//
//  Channel   Handshake                     Ports
//  --------  ----------------------------  ----------------------------------------
//  command   start high while busy is low  i_func, i_a_num, i_a_den, i_b_num, i_b_den
//  result    o_valid high for one cycle    o_res_num, o_res_den, o_div_zero
//
// A division by a zero fraction is answered in the cycle after the command word and
// busy never rises. Otherwise the multiply states S_P0, S_P1 and S_P2 and the sign
// state S_P3 are followed by data dependent binary gcd steps, restoring divisions of
// numerator and denominator by the gcd unless it is 1, and S_OUT, which drives the
// result; a zero numerator or denominator is answered from the sign state S_P3.
// Reset is synchronous and active low; the receiver cannot stall the result word.
module rational_arith_reduce_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_func,
    input  logic signed [rar_pkg::NUM_W-1:0] i_a_num,
    input  logic [rar_pkg::DEN_W-1:0]     i_a_den,
    input  logic signed [rar_pkg::NUM_W-1:0] i_b_num,
    input  logic [rar_pkg::DEN_W-1:0]     i_b_den,
    output logic                          o_valid,
    output logic signed [rar_pkg::RES_W-1:0] o_res_num,
    output logic [rar_pkg::RDEN_W-1:0]    o_res_den,
    output logic                          o_div_zero
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_GCD,
        S_DIV_N,
        S_DIV_D,
        S_OUT
    } t_state;

    t_state r_state;

    // Captured command word.
    logic [1:0]                       r_func;
    logic signed [rar_pkg::NUM_W-1:0] r_an;
    logic signed [rar_pkg::NUM_W-1:0] r_bn;
    logic [rar_pkg::DEN_W-1:0]        r_ad;
    logic [rar_pkg::DEN_W-1:0]        r_bd;

    // Products and the unreduced numerator.
    logic signed [63:0] r_prod;
    logic signed [63:0] r_num;

    // Reduction state: gcd operands, magnitudes (later quotients), remainder.
    logic [63:0] r_u;
    logic [63:0] r_v;
    logic [63:0] r_g;
    logic [63:0] r_nm;
    logic [63:0] r_dm;
    logic [63:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_neg;

    // Shared multiplier.
    logic signed [31:0] mul_x;
    logic signed [31:0] mul_y;
    logic signed [63:0] mul_p;

    // Shared subtractor; the top bit is the borrow.
    logic [64:0] sub_a;
    logic [64:0] sub_b;
    logic [65:0] sub_res;
    logic        sub_borrow;

    logic        num_neg;
    logic        den_neg;
    logic [63:0] num_mag;
    logic [63:0] den_mag;
    logic [63:0] gcd_val;
    logic        q_bit;
    logic [63:0] rem_next;

    // The multiplier operands follow the step: first numerator product, second
    // numerator product (only kept for add and subtract), then the denominator.
    always_comb begin
        case (r_state)
            S_P0: begin
                mul_x = r_an;
                mul_y = (r_func == rar_pkg::FUNC_MUL) ? r_bn : $signed({1'b0, r_bd});
            end
            S_P1: begin
                mul_x = r_bn;
                mul_y = $signed({1'b0, r_ad});
            end
            S_P2: begin
                mul_x = $signed({1'b0, r_ad});
                mul_y = (r_func == rar_pkg::FUNC_DIV) ? r_bn : $signed({1'b0, r_bd});
            end
            default: begin
                mul_x = r_an;
                mul_y = r_bn;
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    // The subtractor serves the gcd compare-and-subtract and both dividers.
    always_comb begin
        case (r_state)
            S_DIV_N: begin
                sub_a = {r_rem, r_nm[63]};
                sub_b = {1'b0, r_g};
            end
            S_DIV_D: begin
                sub_a = {r_rem, r_dm[63]};
                sub_b = {1'b0, r_g};
            end
            default: begin
                sub_a = {1'b0, r_u};
                sub_b = {1'b0, r_v};
            end
        endcase
    end

    assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_res[65];
    assign q_bit      = ~sub_borrow;
    assign rem_next   = sub_borrow ? sub_a[63:0] : sub_res[63:0];

    // Sign and magnitude of the unreduced fraction; r_prod holds the denominator.
    assign num_neg = r_num[63];
    assign den_neg = r_prod[63];
    assign num_mag = num_neg ? (64'd0 - r_num) : r_num;
    assign den_mag = den_neg ? (64'd0 - r_prod) : r_prod;

    // Once one gcd operand is zero the other, with the common powers of two put
    // back, is the gcd.
    assign gcd_val = ((r_u == 64'd0) ? r_v : r_u) << r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            busy       <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func <= i_func;
                        r_an   <= i_a_num;
                        r_ad   <= i_a_den;
                        r_bn   <= i_b_num;
                        r_bd   <= i_b_den;
                        if (i_func == rar_pkg::FUNC_DIV && i_b_num == '0) begin
                            // Division by a zero fraction: flagged, zero result.
                            o_valid    <= 1'b1;
                            o_res_num  <= '0;
                            o_res_den  <= '0;
                            o_div_zero <= 1'b1;
                        end else begin
                            busy    <= 1'b1;
                            r_state <= S_P0;
                        end
                    end
                end
                S_P0: begin
                    r_prod  <= mul_p;
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_num   <= r_prod;
                    r_prod  <= mul_p;
                    r_state <= S_P2;
                end
                S_P2: begin
                    case (r_func)
                        rar_pkg::FUNC_ADD: r_num <= r_num + r_prod;
                        rar_pkg::FUNC_SUB: r_num <= r_num - r_prod;
                        default:           r_num <= r_num;
                    endcase
                    r_prod  <= mul_p;
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_neg <= num_neg ^ den_neg;
                    r_nm  <= num_mag;
                    r_dm  <= den_mag;
                    r_u   <= num_mag;
                    r_v   <= den_mag;
                    r_cnt <= '0;
                    if (r_num == 64'sd0) begin
                        o_valid    <= 1'b1;
                        o_res_num  <= '0;
                        o_res_den  <= 63'd1;
                        o_div_zero <= 1'b0;
                        busy       <= 1'b0;
                        r_state    <= S_IDLE;
                    end else if (den_mag == 64'd0) begin
                        // Only reachable with a zero input denominator.
                        o_valid    <= 1'b1;
                        o_res_num  <= (num_neg ^ den_neg) ? -64'sd1 : 64'sd1;
                        o_res_den  <= '0;
                        o_div_zero <= 1'b0;
                        busy       <= 1'b0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_u == 64'd0 || r_v == 64'd0) begin
                        r_g   <= gcd_val;
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_state <= (gcd_val == 64'd1) ? S_OUT : S_DIV_N;
                    end else begin
                        case ({r_u[0], r_v[0]})
                            2'b00: begin
                                r_u   <= r_u >> 1;
                                r_v   <= r_v >> 1;
                                r_cnt <= r_cnt + 6'd1;
                            end
                            2'b01: r_u <= r_u >> 1;
                            2'b10: r_v <= r_v >> 1;
                            default: begin
                                // Both odd: keep the larger on u, then subtract.
                                if (sub_borrow) begin
                                    r_u <= r_v;
                                    r_v <= r_u;
                                end else begin
                                    r_u <= sub_res[63:0];
                                end
                            end
                        endcase
                    end
                end
                S_DIV_N: begin
                    r_rem <= rem_next;
                    r_nm  <= {r_nm[62:0], q_bit};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == '1) begin
                        r_rem   <= '0;
                        r_state <= S_DIV_D;
                    end
                end
                S_DIV_D: begin
                    r_rem <= rem_next;
                    r_dm  <= {r_dm[62:0], q_bit};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == '1) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_valid    <= 1'b1;
                    o_res_num  <= r_neg ? $signed(64'd0 - r_nm) : $signed(r_nm);
                    o_res_den  <= r_dm[62:0];
                    o_div_zero <= 1'b0;
                    busy       <= 1'b0;
                    r_state    <= S_IDLE;
                end
                default: begin
                    busy    <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // A result word is only ever driven while busy is low: busy drops with it, or never rose.
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted command either answers at once (division by zero) or raises busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || (o_valid && o_div_zero)))
        else $error("accepted command neither answered nor in progress");

    // A flagged division by zero carries a zero result.
    a_div_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_zero) |-> (o_res_num == 64'sd0 && o_res_den == 63'd0))
        else $error("division by zero with a nonzero result");

    // The sequencer is only away from idle while busy is high.
    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> busy)
        else $error("sequencer running without busy");
`endif

endmodule
